// File: src/evr_pkg.sv
package evr_pkg;

  // Field widths of the command and velocity items.
  localparam int CmdW   = 2;
  localparam int TickW  = 16;
  localparam int VelW   = 16;
  localparam int SpanW  = 24;

  // Defaults for the top-level parameters.
  localparam int ExpTableDepthDef = 64;
  localparam int TimeBitsDef      = 24;

  // Command codes.
  localparam logic [CmdW-1:0] CMD_TICK = 2'd0;
  localparam logic [CmdW-1:0] CMD_SET  = 2'd1;
  localparam logic [CmdW-1:0] CMD_INIT = 2'd2;

  localparam longint unsigned Q30One = 64'd1 << 30;

  // Unsigned quotient by shift and subtract, one quotient bit per pass.
  function automatic longint unsigned div_small(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 64'd0;
    rem = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(-step) in Q2.30 by an alternating Taylor series; step is Q2.30 too.
  function automatic longint unsigned exp_base(longint unsigned step);
    longint unsigned term;
    longint unsigned sum;
    term = Q30One;
    sum  = Q30One;
    for (int n = 1; n < 64; n++) begin
      if (term != 64'd0) begin
        term = (term * step) >> 30;
        term = div_small(term, 64'(n));
        if (n[0]) sum = sum - term;
        else      sum = sum + term;
      end
    end
    return sum;
  endfunction

  // Table entry k: base raised to k in Q2.30 with rounding, then cut to Q1.16.
  function automatic logic [16:0] exp_entry(longint unsigned base, int k);
    longint unsigned r;
    longint unsigned rnd;
    r = Q30One;
    for (int j = 0; j < k; j++) begin
      r = (r * base + (Q30One >> 1)) >> 30;
    end
    rnd = (r + 64'd8192) >> 14;
    return rnd[16:0];
  endfunction

endpackage

// File: src/evr_in_if.sv
interface evr_in_if;
  logic                              valid;
  logic                              ready;
  logic        [evr_pkg::CmdW-1:0]   command;
  logic        [evr_pkg::TickW-1:0]  tick_time;
  logic signed [evr_pkg::VelW-1:0]   new_target;
  logic        [evr_pkg::SpanW-1:0]  new_span;

  modport source (output valid, command, tick_time, new_target, new_span, input ready);
  modport sink   (input valid, command, tick_time, new_target, new_span, output ready);
endinterface

// File: src/evr_out_if.sv
interface evr_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [evr_pkg::VelW-1:0] velocity;

  modport source (output valid, velocity, input ready);
  modport sink   (input valid, velocity, output ready);
endinterface

// File: src/exponential_velocity_ramp_top.sv
// Channel   Dir  Payload                                      Handshake
// cmd_i     in   command, tick_time, new_target, new_span     valid/ready
// vel_o     out  velocity                                     valid/ready
//
// A tick with a nonzero span passes through accept, decode, the divider steps
// for the 17-bit time ratio (one quotient bit each), lookup, interpolation and
// scaling, and the output step. A zero-span tick skips the divider and lookup; set, init and unused go to output.
// Reset clears the velocity state and the sequencer at once; no clearing pass.
// A new item is taken while a result waits on vel_o; a stalled vel_o holds
// the sequencer in its output step until the result register frees.
module exponential_velocity_ramp_top #(
  parameter int EXP_TABLE_DEPTH = evr_pkg::ExpTableDepthDef,
  parameter int TIME_BITS       = evr_pkg::TimeBitsDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  evr_in_if.sink     cmd_i,
  evr_out_if.source  vel_o
);

  localparam int IdxW     = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int ProdPW   = 17 + IdxW;
  localparam int SpanExtW = (TIME_BITS > evr_pkg::SpanW) ? TIME_BITS : evr_pkg::SpanW;
  localparam int DivSteps = 16;
  localparam int CntW     = $clog2(DivSteps + 1);
  localparam longint unsigned ExpStep = (64'd5 << 30) / EXP_TABLE_DEPTH;
  localparam longint unsigned ExpBase = evr_pkg::exp_base(ExpStep);
  localparam logic [IdxW-1:0] DepthK  = IdxW'(EXP_TABLE_DEPTH);

  // Microprogram.
  typedef enum logic [3:0] {
    OP_WAIT, OP_DECODE, OP_DIV_INIT, OP_DIV_STEP, OP_MUL_DEPTH, OP_READ_LO,
    OP_READ_HI, OP_DIFF, OP_EXP, OP_SCALE, OP_SUM, OP_GOAL, OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER, C_ALWAYS, C_NO_INPUT, C_NOT_TICK, C_SPAN_ZERO, C_CNT_MORE, C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e        op;
    cond_e      cond;
    logic [3:0] target;
  } uword_t;

  localparam int ProgLen = 13;
  localparam logic [3:0] PcWait    = 4'd0;
  localparam logic [3:0] PcDivStep = 4'd3;
  localparam logic [3:0] PcGoal    = 4'd11;
  localparam logic [3:0] PcEmit    = 4'd12;
  localparam logic [3:0] PcLast    = 4'(ProgLen - 1);

  localparam uword_t Program [ProgLen] = '{
    '{OP_WAIT,      C_NO_INPUT,  PcWait},
    '{OP_DECODE,    C_NOT_TICK,  PcEmit},
    '{OP_DIV_INIT,  C_SPAN_ZERO, PcGoal},
    '{OP_DIV_STEP,  C_CNT_MORE,  PcDivStep},
    '{OP_MUL_DEPTH, C_NEVER,     PcWait},
    '{OP_READ_LO,   C_NEVER,     PcWait},
    '{OP_READ_HI,   C_NEVER,     PcWait},
    '{OP_DIFF,      C_NEVER,     PcWait},
    '{OP_EXP,       C_NEVER,     PcWait},
    '{OP_SCALE,     C_NEVER,     PcWait},
    '{OP_SUM,       C_ALWAYS,    PcEmit},
    '{OP_GOAL,      C_NEVER,     PcWait},
    '{OP_EMIT,      C_OUT_BUSY,  PcEmit}
  };

  // Exponential table, exp(-5k/depth) in Q1.16, built at elaboration.
  logic [16:0] exp_rom [EXP_TABLE_DEPTH + 1];

  for (genvar k = 0; k <= EXP_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [16:0] Entry = evr_pkg::exp_entry(ExpBase, k);
    assign exp_rom[k] = Entry;
  end

  // Sequencer and architectural state.
  logic        [3:0]             pc_q, pc_d;
  logic signed [15:0]            vel_q, goal_q, start_q;
  logic        [TIME_BITS-1:0]   span_q, elapsed_q;
  logic                          out_valid_q;

  // Latched item and datapath registers.
  logic        [1:0]             cmd_q;
  logic        [15:0]            tick_q;
  logic signed [15:0]            tgt_q;
  logic        [TIME_BITS-1:0]   span_in_q;
  logic        [TIME_BITS-1:0]   rem_q;
  logic        [16:0]            x_q;
  logic        [CntW-1:0]        cnt_q;
  logic        [ProdPW-1:0]      p_q;
  logic        [16:0]            rom_q, e0_q, g_q;
  logic        [32:0]            dprod_q;
  logic signed [34:0]            sprod_q;
  logic signed [15:0]            out_vel_q;

  uword_t                        uword;
  logic                          jump;
  logic                          out_free;
  logic        [SpanExtW-1:0]    span_ext;
  logic        [TIME_BITS:0]     elapsed_sum;
  logic        [TIME_BITS-1:0]   elapsed_sat;
  logic        [TIME_BITS:0]     rem2;
  logic                          rem_ge;
  logic        [IdxW-1:0]        idx_lo, idx_hi;
  logic        [IdxW:0]          idx_inc;
  logic        [16:0]            exp_val, g_val;
  logic signed [16:0]            range_v;
  logic signed [18:0]            rounded;
  logic signed [19:0]            res_wide;
  logic signed [15:0]            res_clamped;
  logic        [33:0]            dround;

  assign uword    = Program[pc_q];
  assign out_free = !out_valid_q || vel_o.ready;

  // Handshake outputs.
  assign cmd_i.ready    = (pc_q == PcWait);
  assign vel_o.valid    = out_valid_q;
  assign vel_o.velocity = out_vel_q;

  // Span masked to the time width.
  assign span_ext = SpanExtW'(cmd_i.new_span);

  // Elapsed time, saturating at the span.
  assign elapsed_sum = {1'b0, elapsed_q} + (TIME_BITS + 1)'(tick_q);
  assign elapsed_sat = (elapsed_sum > {1'b0, span_q}) ? span_q : elapsed_sum[TIME_BITS-1:0];

  // One restoring divider step.
  assign rem2   = {rem_q, 1'b0};
  assign rem_ge = (rem2 >= {1'b0, span_q});

  // Table indexes, the upper one held at the last entry.
  assign idx_lo  = p_q[16 +: IdxW];
  assign idx_inc = {1'b0, idx_lo} + (IdxW + 1)'(1);
  assign idx_hi  = (idx_lo == DepthK) ? idx_lo : idx_inc[IdxW-1:0];

  // Interpolated exponential and the step 1 - e.
  assign dround  = {1'b0, dprod_q} + 34'd32768;
  assign exp_val = e0_q - dround[32:16];
  assign g_val   = 17'h10000 - exp_val;

  // Scaled range rounded half up, added to the start and clamped.
  assign range_v     = 17'(goal_q) - 17'(start_q);
  assign rounded     = 19'((sprod_q + 35'sd32768) >>> 16);
  assign res_wide    = 20'(start_q) + 20'(rounded);
  assign res_clamped = (res_wide > 20'sd32767)  ? 16'sh7FFF :
                       (res_wide < -20'sd32768) ? 16'sh8000 : res_wide[15:0];

  // Jump condition and next step.
  always_comb begin
    unique case (uword.cond)
      C_NEVER:     jump = 1'b0;
      C_ALWAYS:    jump = 1'b1;
      C_NO_INPUT:  jump = !cmd_i.valid;
      C_NOT_TICK:  jump = (cmd_q != evr_pkg::CMD_TICK);
      C_SPAN_ZERO: jump = (span_q == '0);
      C_CNT_MORE:  jump = (cnt_q != CntW'(1));
      C_OUT_BUSY:  jump = !out_free;
      default:     jump = 1'b0;
    endcase
    if (jump) begin
      pc_d = uword.target;
    end else if (pc_q == PcLast) begin
      pc_d = PcWait;
    end else begin
      pc_d = pc_q + 4'd1;
    end
  end

  // Control and velocity state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PcWait;
      out_valid_q <= 1'b0;
      vel_q       <= '0;
      goal_q      <= '0;
      start_q     <= '0;
      span_q      <= '0;
      elapsed_q   <= '0;
    end else begin
      pc_q <= pc_d;
      // The result register fills in the output step and frees when taken.
      if (uword.op == OP_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && vel_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (uword.op)
        OP_DECODE: begin
          case (cmd_q)
            evr_pkg::CMD_TICK: elapsed_q <= elapsed_sat;
            evr_pkg::CMD_SET: begin
              start_q   <= vel_q;
              goal_q    <= tgt_q;
              span_q    <= span_in_q;
              elapsed_q <= '0;
            end
            evr_pkg::CMD_INIT: begin
              vel_q     <= '0;
              start_q   <= tgt_q;
              goal_q    <= tgt_q;
              span_q    <= span_in_q;
              elapsed_q <= '0;
            end
            default: ;
          endcase
        end
        OP_SUM:  vel_q <= res_clamped;
        OP_GOAL: vel_q <= goal_q;
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (uword.op)
      OP_WAIT: begin
        if (cmd_i.valid) begin
          cmd_q     <= cmd_i.command;
          tick_q    <= cmd_i.tick_time;
          tgt_q     <= cmd_i.new_target;
          span_in_q <= span_ext[TIME_BITS-1:0];
        end
      end
      OP_DIV_INIT: begin
        // Elapsed never exceeds the span, so the top quotient bit is one
        // only when they are equal, leaving no remainder.
        cnt_q <= CntW'(DivSteps);
        if (elapsed_q >= span_q) begin
          x_q   <= 17'd1;
          rem_q <= '0;
        end else begin
          x_q   <= 17'd0;
          rem_q <= elapsed_q;
        end
      end
      OP_DIV_STEP: begin
        x_q   <= {x_q[15:0], rem_ge};
        rem_q <= rem_ge ? TIME_BITS'(rem2 - {1'b0, span_q}) : rem2[TIME_BITS-1:0];
        cnt_q <= cnt_q - CntW'(1);
      end
      OP_MUL_DEPTH: p_q <= ProdPW'(x_q) * ProdPW'(DepthK);
      OP_READ_LO:   rom_q <= exp_rom[idx_lo];
      OP_READ_HI: begin
        e0_q  <= rom_q;
        rom_q <= exp_rom[idx_hi];
      end
      OP_DIFF:  dprod_q <= 33'(e0_q - rom_q) * 33'(p_q[15:0]);
      OP_EXP:   g_q     <= g_val;
      OP_SCALE: sprod_q <= 35'(range_v) * 35'(signed'({1'b0, g_q}));
      OP_EMIT: begin
        if (out_free) begin
          out_vel_q <= vel_q;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: bench/tb_exponential_velocity_ramp_top.sv
`timescale 1ns / 100ps

module tb_exponential_velocity_ramp_top;

  localparam int TableDepth    = evr_pkg::ExpTableDepthDef;
  localparam int TimeBits      = evr_pkg::TimeBitsDef;
  localparam int CmdW          = evr_pkg::CmdW;
  localparam int TickW         = evr_pkg::TickW;
  localparam int VelW          = evr_pkg::VelW;
  localparam int SpanW         = evr_pkg::SpanW;
  localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;
  localparam int RandomPerPhase = 580;
  localparam int HoldOffCycles  = 400;
  localparam int WatchdogLimit  = 4000;
  localparam int TailCycles     = 40;
  localparam int ReportLimit    = 10;

  // Tracks the ramp state, works out the velocity each item should report and
  // compares the block's results in order.
  class ramp_scoreboard;
    logic signed [VelW-1:0] vel_now;
    logic signed [VelW-1:0] goal_vel;
    logic signed [VelW-1:0] start_vel;
    logic [TimeBits-1:0]    span_us;
    logic [TimeBits-1:0]    elapsed_us;
    longint unsigned        exp_tab[0:TableDepth];
    logic signed [VelW-1:0] expected_velocity_q[$];
    int mismatches;
    int checked;
    int n_tick;
    int n_full;
    int n_zero_span;
    int n_set;
    int n_init;
    int n_unused;

    function new();
      build_exp_table();
      vel_now    = '0;
      goal_vel   = '0;
      start_vel  = '0;
      span_us    = '0;
      elapsed_us = '0;
    endfunction

    // Q1.16 samples of exp(-5k/depth), built by powers of a Taylor-series base.
    function void build_exp_table();
      longint unsigned one;
      longint unsigned step;
      longint unsigned term;
      longint unsigned base;
      longint unsigned r;
      one  = 64'd1 << 30;
      step = (64'd5 * one) / TableDepth;
      term = one;
      base = one;
      for (int n = 1; n < 64 && term != 0; n++) begin
        term = (term * step) >> 30;
        term = term / n;
        if (n % 2 == 1) base = base - term;
        else            base = base + term;
      end
      r = one;
      exp_tab[0] = (r + 64'd8192) >> 14;
      for (int k = 1; k <= TableDepth; k++) begin
        r = (r * base + (one >> 1)) >> 30;
        exp_tab[k] = (r + 64'd8192) >> 14;
      end
    endfunction

    // Velocity along the exponential profile for the present elapsed time.
    function logic signed [VelW-1:0] shaped_velocity();
      longint unsigned ratio;
      longint unsigned pos;
      longint unsigned idx;
      longint unsigned frac;
      longint unsigned decay;
      longint unsigned delta;
      longint unsigned gain;
      longint          swing;
      longint          res;
      if (span_us == 0) return goal_vel;
      ratio = (longint'(elapsed_us) << 16) / longint'(span_us);
      if (ratio > 65536) ratio = 65536;
      pos  = ratio * TableDepth;
      idx  = pos >> 16;
      frac = pos & 64'hFFFF;
      if (idx >= TableDepth) begin
        decay = exp_tab[TableDepth];
      end else begin
        delta = exp_tab[idx] - exp_tab[idx + 1];
        decay = exp_tab[idx] - ((delta * frac + 64'd32768) >> 16);
      end
      gain  = 64'd65536 - decay;
      swing = longint'(goal_vel) - longint'(start_vel);
      // Arithmetic shift gives the floor, so this rounds half up.
      res = longint'(start_vel) + ((swing * $signed(gain) + 64'sd32768) >>> 16);
      if (res > 32767)  res = 32767;
      if (res < -32768) res = -32768;
      return res[VelW-1:0];
    endfunction

    // Applies one accepted item and queues the velocity it must report.
    function void note_command(logic [CmdW-1:0] cmd, logic [TickW-1:0] tick,
                               logic signed [VelW-1:0] target, logic [SpanW-1:0] span);
      longint unsigned el;
      case (cmd)
        evr_pkg::CMD_TICK: begin
          el = longint'(elapsed_us) + longint'(tick);
          if (el > span_us) el = span_us;
          elapsed_us = el[TimeBits-1:0];
          vel_now = shaped_velocity();
          n_tick++;
          if (span_us == 0)                n_zero_span++;
          else if (elapsed_us == span_us) n_full++;
        end
        evr_pkg::CMD_SET: begin
          start_vel  = vel_now;
          goal_vel   = target;
          span_us    = span[TimeBits-1:0];
          elapsed_us = '0;
          n_set++;
        end
        evr_pkg::CMD_INIT: begin
          vel_now    = '0;
          goal_vel   = target;
          start_vel  = target;
          span_us    = span[TimeBits-1:0];
          elapsed_us = '0;
          n_init++;
        end
        default: n_unused++;
      endcase
      expected_velocity_q.push_back(vel_now);
    endfunction

    // Compares one result with the oldest expected velocity.
    function void check_velocity(logic signed [VelW-1:0] actual);
      logic signed [VelW-1:0] want;
      if (expected_velocity_q.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("%0t: unexpected velocity %0d with nothing outstanding", $realtime, actual);
        return;
      end
      want = expected_velocity_q.pop_front();
      checked++;
      if (actual !== want) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("%0t: velocity mismatch, expected %0d, got %0d", $realtime, want, actual);
      end
    endfunction

    function int outstanding();
      return expected_velocity_q.size();
    endfunction

    // Anything still outstanding at the end counts as a failure.
    function void close_out();
      if (expected_velocity_q.size() != 0) begin
        $display("%0d expected velocities never arrived", expected_velocity_q.size());
        mismatches += expected_velocity_q.size();
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int hold_len;
  int quiet_cycles;
  ramp_scoreboard ramp_sb;

  evr_in_if  cmd_if ();
  evr_out_if vel_if ();

  exponential_velocity_ramp_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .vel_o  (vel_if)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offers one item and waits until the block takes it.
  task automatic send_item(input logic [CmdW-1:0] cmd, input logic [TickW-1:0] tick,
                           input logic signed [VelW-1:0] target,
                           input logic [SpanW-1:0] span);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.command    <= cmd;
    cmd_if.tick_time  <= tick;
    cmd_if.new_target <= target;
    cmd_if.new_span   <= span;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    ramp_sb.note_command(cmd, tick, target, span);
  endtask

  // Extremes, every command and the special cases of the profile.
  task automatic directed_items();
    send_item(evr_pkg::CMD_TICK, 16'd0, 16'sd0, 24'd0);       // zero span straight from reset
    send_item(evr_pkg::CMD_INIT, 16'd0, 16'sd32767, 24'd0);
    send_item(evr_pkg::CMD_TICK, 16'hFFFF, 16'sd0, 24'd0);    // zero span jumps to the goal
    send_item(evr_pkg::CMD_SET, 16'd0, -16'sd32768, 24'hFFFFFF);   // longest span
    send_item(evr_pkg::CMD_TICK, 16'hFFFF, 16'sd0, 24'd0);
    send_item(evr_pkg::CMD_TICK, 16'hFFFF, 16'sd0, 24'd0);
    send_item(CMD_UNUSED, 16'd777, 16'sd12345, 24'd999);      // ignored command
    send_item(evr_pkg::CMD_INIT, 16'hFFFF, -16'sd32768, 24'd0);
    send_item(evr_pkg::CMD_TICK, 16'd0, 16'sd0, 24'hFFFFFF);
    send_item(evr_pkg::CMD_SET, 16'hFFFF, 16'sd32767, 24'd100000);  // full-scale swing
    send_item(evr_pkg::CMD_TICK, 16'd1, 16'sd0, 24'd0);
    send_item(evr_pkg::CMD_TICK, 16'd50000, 16'sd0, 24'd0);
    send_item(evr_pkg::CMD_TICK, 16'hFFFF, 16'sd0, 24'd0);    // elapsed runs past the span
    send_item(evr_pkg::CMD_TICK, 16'hFFFF, 16'sd0, 24'd0);
    send_item(evr_pkg::CMD_SET, 16'd0, 16'sd0, 24'd1);
    send_item(evr_pkg::CMD_TICK, 16'd0, 16'sd0, 24'd0);       // no time passed yet
    send_item(evr_pkg::CMD_TICK, 16'd1, 16'sd0, 24'd0);
    send_item(evr_pkg::CMD_SET, 16'd0, -16'sd32768, 24'hFFFFFF);
    send_item(evr_pkg::CMD_TICK, 16'hFFFF, 16'sd0, 24'd0);
    send_item(evr_pkg::CMD_SET, 16'd0, 16'sd5, 24'd0);
    send_item(evr_pkg::CMD_TICK, 16'd0, 16'sd0, 24'd0);
    send_item(CMD_UNUSED, 16'hFFFF, -16'sd1, 24'hFFFFFF);
    send_item(evr_pkg::CMD_TICK, 16'd3, 16'sd0, 24'd0);
  endtask

  // Mostly set-then-tick ramps with random content, with some noise mixed in.
  task automatic random_items(input int n_items);
    int done_items;
    int kind;
    int n_ticks;
    int unsigned stride;
    logic [SpanW-1:0] span;
    logic [TickW-1:0] tick;
    logic signed [VelW-1:0] target;
    logic [CmdW-1:0] cmd;
    done_items = 0;
    while (done_items < n_items) begin
      kind   = $urandom_range(99);
      tick   = $urandom();
      target = $urandom();
      span   = $urandom();
      if (kind < 4) begin
        send_item(CMD_UNUSED, tick, target, span);
        done_items++;
      end else if (kind < 12) begin
        cmd = ($urandom_range(2) == 0) ? evr_pkg::CMD_TICK :
              ($urandom_range(1) == 0) ? evr_pkg::CMD_SET : evr_pkg::CMD_INIT;
        send_item(cmd, tick, target, span);
        done_items++;
      end else begin
        case ($urandom_range(9))
          0:       span = '0;
          1:       span = $urandom_range(64, 1);
          2:       span = $urandom();
          default: span = $urandom_range(200000, 100);
        endcase
        case ($urandom_range(9))
          0:       target = -16'sd32768;
          1:       target = 16'sd32767;
          default: target = $urandom();
        endcase
        cmd = ($urandom_range(99) < 15) ? evr_pkg::CMD_INIT : evr_pkg::CMD_SET;
        send_item(cmd, tick, target, span);
        n_ticks = $urandom_range(12, 1);
        stride  = span / n_ticks * 2;
        if (stride > 65535 || span == 0) stride = 65535;
        for (int j = 0; j < n_ticks; j++) begin
          tick = $urandom_range(stride, 0);
          send_item(evr_pkg::CMD_TICK, tick, target, span);
        end
        done_items += 1 + n_ticks;
      end
    end
  endtask

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    vel_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_len != 0 && !hold_done) begin
        hold_left = hold_len;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        vel_if.ready <= 1'b0;
        hold_left--;
      end else begin
        vel_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Result checking and the watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (vel_if.valid && vel_if.ready) ramp_sb.check_velocity(vel_if.velocity);
      if ((vel_if.valid && vel_if.ready) || (cmd_if.valid && cmd_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Timeout: no item moved in %0d cycles", WatchdogLimit);
        $display("FAIL");
        $finish;
      end
    end
  end

  // Main sequence.
  initial begin
    ramp_sb = new();
    quiet_cycles = 0;
    hold_len = 0;
    send_idle_pct = 13;
    recv_idle_pct = 66;
    cmd_if.valid = 1'b0;
    cmd_if.command = evr_pkg::CMD_TICK;
    cmd_if.tick_time = '0;
    cmd_if.new_target = '0;
    cmd_if.new_span = '0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    directed_items();
    random_items(RandomPerPhase);

    send_idle_pct = 66;
    recv_idle_pct = 13;
    random_items(RandomPerPhase);

    // No idling; the result side holds off once so the block backs up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_len = HoldOffCycles;
    random_items(RandomPerPhase);

    @(negedge clk_i);
    cmd_if.valid <= 1'b0;
    while (ramp_sb.outstanding() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    ramp_sb.close_out();

    $display("Ran %0d ticks (%0d at full span, %0d with zero span), %0d sets, %0d inits,",
             ramp_sb.n_tick, ramp_sb.n_full, ramp_sb.n_zero_span, ramp_sb.n_set,
             ramp_sb.n_init);
    $display("%0d unused commands; %0d velocities checked, %0d mismatches.",
             ramp_sb.n_unused, ramp_sb.checked, ramp_sb.mismatches);
    if (ramp_sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
